[design/pfx_pkg.sv]
// ----------------------------------------------------------------------------
// pfx_pkg
// shared constants for the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfx_pkg;

    // operand stack geometry
    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // datapath
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = ((DATA_W + STATUS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - STATUS_W;

    // iterative divider
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

    // expression characters
    localparam logic [SYM_W-1:0] CHAR_0     = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_9     = 8'h39;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_DIV   = 8'h2F;

endpackage

[design/postfix_expression_evaluator_top.sv]
// sequence: a digit is pushed as it is accepted; + - * and unknown operators go through
// accept, two stack reads, execute and write back; / adds the radix-2 divider,
// which resolves one quotient bit per cycle, and a sign fix before write back (both skipped on zero divisor)
// an end-marked transaction then reads the top of stack before the result is registered
// one transaction in flight at a time; results wait in an output register
// reset: asynchronous active low, clears stack count, sticky error and control
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// reverse polish evaluator: operand stack in a synchronous ram, a shared
// read-modify-write sequencer, a multiplier and an iterative divider
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top
(
    input  logic                               clk,
    input  logic                               rst_n,

    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pfx_pkg::SYM_W-1:0]          s_tdata,   // [7:0] symbol
    input  logic                               s_tlast,   // end_of_expression

    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pfx_pkg::OUT_TDATA_W-1:0]    m_tdata    // [31:0] value, [33:32] status, zero pad
);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,     // waiting for a transaction, digits pushed here
        S_RD_B,     // top operand returning from ram, issue read of the one below
        S_RD_A,     // lower operand returning from ram
        S_EXEC,     // add, subtract, multiply or set up the divider
        S_DIV,      // one quotient bit per cycle
        S_FIX,      // sign correction of the quotient
        S_WB,       // write the result back onto the stack
        S_END_RD,   // read the top of stack for the result
        S_EMIT      // load the output register when it is free
    } state_t;

    state_t                          state_reg, state_next;
    logic [pfx_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [pfx_pkg::STATUS_W-1:0]    err_reg, err_next;
    logic                            last_reg, last_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [pfx_pkg::SYM_W-1:0]       sym_reg;
    logic [pfx_pkg::DATA_W-1:0]      a_reg;
    logic [pfx_pkg::DATA_W-1:0]      b_reg;
    logic [pfx_pkg::DATA_W-1:0]      res_reg;
    logic [pfx_pkg::DATA_W:0]        rem_reg;
    logic [pfx_pkg::DATA_W-1:0]      quo_reg;
    logic [pfx_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic                            neg_reg;
    logic [pfx_pkg::DATA_W-1:0]      out_value_reg;
    logic [pfx_pkg::STATUS_W-1:0]    out_status_reg;

    // operand stack ram
    logic [pfx_pkg::DATA_W-1:0]      stack_mem [pfx_pkg::STACK_DEPTH];
    logic [pfx_pkg::DATA_W-1:0]      rd_data_reg;
    logic                            mem_we;
    logic [pfx_pkg::PTR_W-1:0]       mem_waddr;
    logic [pfx_pkg::DATA_W-1:0]      mem_wdata;
    logic [pfx_pkg::PTR_W-1:0]       mem_raddr;

    logic                            s_accept;
    logic                            is_digit;
    logic                            out_load;
    logic [pfx_pkg::CNT_W-1:0]       cnt_m1;
    logic [pfx_pkg::CNT_W-1:0]       cnt_m2;
    logic [pfx_pkg::DATA_W:0]        rem_shift;
    logic [pfx_pkg::DATA_W:0]        div_diff;
    logic [pfx_pkg::DATA_W-1:0]      quo_step;
    logic [pfx_pkg::DATA_W:0]        rem_step;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{pfx_pkg::OUT_PAD_W{1'b0}}, out_status_reg, out_value_reg};

    assign is_digit = (s_tdata >= pfx_pkg::CHAR_0) && (s_tdata <= pfx_pkg::CHAR_9);
    assign cnt_m1   = cnt_reg - pfx_pkg::CNT_W'(1);
    assign cnt_m2   = cnt_reg - pfx_pkg::CNT_W'(2);

    // restoring division step on magnitudes
    assign rem_shift = {rem_reg[pfx_pkg::DATA_W-1:0], quo_reg[pfx_pkg::DATA_W-1]};
    assign div_diff  = rem_shift - {1'b0, b_reg};
    assign rem_step  = div_diff[pfx_pkg::DATA_W] ? rem_shift : div_diff;
    assign quo_step  = {quo_reg[pfx_pkg::DATA_W-2:0], ~div_diff[pfx_pkg::DATA_W]};

    // output register is free or being drained this cycle
    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------------
    // sequencer next state and ram control
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg[pfx_pkg::PTR_W-1:0];
        mem_wdata     = res_reg;
        // top of stack by default
        mem_raddr     = cnt_m1[pfx_pkg::PTR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    last_next = s_tlast;
                    if (is_digit)
                    begin
                        if (cnt_reg == pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH))
                        begin
                            if (err_reg == pfx_pkg::ST_OK)
                            begin
                                err_next = pfx_pkg::ST_OVERFLOW;
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = pfx_pkg::DATA_W'(s_tdata - pfx_pkg::CHAR_0);
                            cnt_next  = cnt_reg + pfx_pkg::CNT_W'(1);
                        end
                        state_next = s_tlast ? S_END_RD : S_IDLE;
                    end
                    else if (cnt_reg < pfx_pkg::CNT_W'(2))
                    begin
                        // too few operands: stack left alone
                        if (err_reg == pfx_pkg::ST_OK)
                        begin
                            err_next = pfx_pkg::ST_UNDERFLOW;
                        end
                        state_next = s_tlast ? S_END_RD : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD_B;
                    end
                end
            end
            S_RD_B:
            begin
                mem_raddr  = cnt_m2[pfx_pkg::PTR_W-1:0];
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sym_reg == pfx_pkg::CHAR_DIV)
                begin
                    if (b_reg == '0)
                    begin
                        if (err_reg == pfx_pkg::ST_OK)
                        begin
                            err_next = pfx_pkg::ST_DIVZERO;
                        end
                        state_next = S_WB;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == pfx_pkg::DIV_CNT_W'(pfx_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                // two popped, one pushed: the slot below the old top
                mem_we     = 1'b1;
                mem_waddr  = cnt_m2[pfx_pkg::PTR_W-1:0];
                cnt_next   = cnt_m1;
                state_next = last_reg ? S_END_RD : S_IDLE;
            end
            S_END_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    cnt_next      = '0;
                    err_next      = pfx_pkg::ST_OK;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // control state and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            err_reg      <= pfx_pkg::ST_OK;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            err_reg      <= err_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // ------------------------------------------------------------------------
    // datapath: operands, arithmetic, divider and result payload
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sym_reg <= s_tdata;
        end

        unique case (state_reg)
            S_RD_B:
            begin
                b_reg <= rd_data_reg;
            end
            S_RD_A:
            begin
                a_reg <= rd_data_reg;
            end
            S_EXEC:
            begin
                unique case (sym_reg)
                    pfx_pkg::CHAR_PLUS:  res_reg <= a_reg + b_reg;
                    pfx_pkg::CHAR_MINUS: res_reg <= a_reg - b_reg;
                    pfx_pkg::CHAR_MUL:   res_reg <= a_reg * b_reg;
                    pfx_pkg::CHAR_DIV:
                    begin
                        res_reg     <= '0;
                        quo_reg     <= a_reg[pfx_pkg::DATA_W-1] ? -a_reg : a_reg;
                        b_reg       <= b_reg[pfx_pkg::DATA_W-1] ? -b_reg : b_reg;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        neg_reg     <= a_reg[pfx_pkg::DATA_W-1] ^ b_reg[pfx_pkg::DATA_W-1];
                    end
                    default:             res_reg <= '0;
                endcase
            end
            S_DIV:
            begin
                rem_reg     <= rem_step;
                quo_reg     <= quo_step;
                div_cnt_reg <= div_cnt_reg + pfx_pkg::DIV_CNT_W'(1);
            end
            S_FIX:
            begin
                res_reg <= neg_reg ? -quo_reg : quo_reg;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            if (cnt_reg == '0)
            begin
                // empty stack at the end reads as zero, with underflow unless an earlier error stands
                out_value_reg  <= '0;
                out_status_reg <= (err_reg == pfx_pkg::ST_OK) ? pfx_pkg::ST_UNDERFLOW : err_reg;
            end
            else
            begin
                out_value_reg  <= rd_data_reg;
                out_status_reg <= err_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // operand stack: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

endmodule

[bench/postfix_expression_evaluator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top_tb
// self-checking bench: a stimulus table of short expressions, then random
// well-formed, broken and noisy expressions, scored against typed rows or an in-bench
// operand stack model, with bursty input, a stalling sink and a long hold-off
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top_tb;

    localparam int ITEM_TARGET = 1250;   // input transactions before the stimulus stops
    localparam int HOLD_CYCLES = 600;    // one long sink hold-off to back the block up
    localparam int STALL_LIMIT = 4000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 64;    // margin for the slowest item, a divide

    typedef struct packed {
        logic [pfx_pkg::DATA_W-1:0]   value;
        logic [pfx_pkg::STATUS_W-1:0] status;
    } result_t;

    // one row of the stimulus table; value and status count only when checked is set
    typedef struct packed {
        logic [pfx_pkg::SYM_W-1:0]    sym;
        logic                         last;
        logic                         checked;
        logic [pfx_pkg::DATA_W-1:0]   value;
        logic [pfx_pkg::STATUS_W-1:0] status;
    } stim_row_t;

    localparam int DIRECTED_LEN = 25;
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
        // operator on an empty stack, then end with nothing to show
        '{pfx_pkg::CHAR_PLUS,     1'b1, 1'b1, 32'd0,         pfx_pkg::ST_UNDERFLOW},
        // both digit extremes and an add
        '{pfx_pkg::CHAR_0,        1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_9,        1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_PLUS,     1'b1, 1'b1, 32'd9,         pfx_pkg::ST_OK},
        // subtract going negative: 3 - 7
        '{pfx_pkg::CHAR_0 + 8'd3, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0 + 8'd7, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_MINUS,    1'b1, 1'b1, 32'hFFFF_FFFC, pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_9,        1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0 + 8'd8, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_MUL,      1'b1, 1'b1, 32'd72,        pfx_pkg::ST_OK},
        // negative dividend truncates toward zero, left to the model
        '{pfx_pkg::CHAR_0,        1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0 + 8'd7, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_MINUS,    1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0 + 8'd2, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_DIV,      1'b1, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        // divide by zero
        '{pfx_pkg::CHAR_9,        1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0,        1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_DIV,      1'b1, 1'b1, 32'd0,         pfx_pkg::ST_DIVZERO},
        // unknown operator, all ones
        '{pfx_pkg::CHAR_0 + 8'd4, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0 + 8'd5, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{8'hFF,                  1'b1, 1'b1, 32'd0,         pfx_pkg::ST_OK},
        // short operator (all zeros) leaves the stack alone, error sticks
        '{pfx_pkg::CHAR_0 + 8'd5, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{8'h00,                  1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_0 + 8'd2, 1'b0, 1'b0, 32'd0,         pfx_pkg::ST_OK},
        '{pfx_pkg::CHAR_DIV,      1'b1, 1'b1, 32'd2,         pfx_pkg::ST_UNDERFLOW}
    };

    // ------------------------------------------------------------------------
    // dut ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pfx_pkg::SYM_W-1:0]       s_tdata  = '0;     // [7:0] symbol
    logic                            s_tlast  = 1'b0;   // end_of_expression
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pfx_pkg::OUT_TDATA_W-1:0] m_tdata;           // [31:0] value, [33:32] status, zero pad

    postfix_expression_evaluator_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // operand stack model
    // ------------------------------------------------------------------------
    logic [pfx_pkg::DATA_W-1:0]   calc_stack [pfx_pkg::STACK_DEPTH];
    int unsigned                  calc_depth = 0;
    logic [pfx_pkg::STATUS_W-1:0] calc_error = pfx_pkg::ST_OK;

    result_t                      awaited_results [$];   // results still owed by the block
    int unsigned                  fault_count = 0;
    int unsigned                  items_sent  = 0;
    int unsigned                  burst_left  = 1;
    bit                           hold_wanted = 1'b0;
    logic [pfx_pkg::SYM_W-1:0]    expr_chars [$];        // expression being built
    int unsigned                  idle_cycles = 0;

    // only the first error of an expression is kept
    function automatic void record_error(input logic [pfx_pkg::STATUS_W-1:0] code);
        if (calc_error == pfx_pkg::ST_OK)
            calc_error = code;
    endfunction

    // a push onto a full stack is dropped
    function automatic void push_operand(input logic [pfx_pkg::DATA_W-1:0] v);
        if (calc_depth < pfx_pkg::STACK_DEPTH)
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
        else
            record_error(pfx_pkg::ST_OVERFLOW);
    endfunction

    // sign and magnitude so that most negative over minus one simply wraps
    function automatic logic [pfx_pkg::DATA_W-1:0] divide_toward_zero(
        input logic [pfx_pkg::DATA_W-1:0] a,
        input logic [pfx_pkg::DATA_W-1:0] b);
        logic [pfx_pkg::DATA_W-1:0] mag_a;
        logic [pfx_pkg::DATA_W-1:0] mag_b;
        logic [pfx_pkg::DATA_W-1:0] quo;
        mag_a = a[pfx_pkg::DATA_W-1] ? -a : a;
        mag_b = b[pfx_pkg::DATA_W-1] ? -b : b;
        quo   = mag_a / mag_b;
        return (a[pfx_pkg::DATA_W-1] ^ b[pfx_pkg::DATA_W-1]) ? -quo : quo;
    endfunction

    // steps the model by one symbol, returns 1 when the symbol ends an expression
    function automatic bit evaluate_symbol(input logic [pfx_pkg::SYM_W-1:0] sym,
                                           input logic last,
                                           output result_t res);
        logic [pfx_pkg::DATA_W-1:0] lhs;
        logic [pfx_pkg::DATA_W-1:0] rhs;
        logic [pfx_pkg::DATA_W-1:0] r;
        res = '0;
        if (sym >= pfx_pkg::CHAR_0 && sym <= pfx_pkg::CHAR_9)
            push_operand(pfx_pkg::DATA_W'(sym - pfx_pkg::CHAR_0));
        else if (calc_depth < 2)
            record_error(pfx_pkg::ST_UNDERFLOW);
        else
        begin
            rhs = calc_stack[calc_depth - 1];
            lhs = calc_stack[calc_depth - 2];
            calc_depth -= 2;
            case (sym)
                pfx_pkg::CHAR_PLUS:  r = lhs + rhs;
                pfx_pkg::CHAR_MINUS: r = lhs - rhs;
                pfx_pkg::CHAR_MUL:   r = lhs * rhs;
                pfx_pkg::CHAR_DIV:
                begin
                    if (rhs == '0)
                    begin
                        r = '0;
                        record_error(pfx_pkg::ST_DIVZERO);
                    end
                    else
                        r = divide_toward_zero(lhs, rhs);
                end
                default:             r = '0;
            endcase
            push_operand(r);
        end
        if (!last)
            return 1'b0;
        if (calc_depth == 0)
        begin
            res.value = '0;
            record_error(pfx_pkg::ST_UNDERFLOW);
        end
        else
            res.value = calc_stack[calc_depth - 1];
        res.status = calc_error;
        calc_depth = 0;
        calc_error = pfx_pkg::ST_OK;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // expression builders
    // ------------------------------------------------------------------------
    function automatic logic [pfx_pkg::SYM_W-1:0] pick_digit();
        return pfx_pkg::CHAR_0 + pfx_pkg::SYM_W'($urandom_range(0, 9));
    endfunction

    // mostly arithmetic, now and then a character that is neither digit nor operator
    function automatic logic [pfx_pkg::SYM_W-1:0] pick_operator();
        logic [pfx_pkg::SYM_W-1:0] sym;
        case ($urandom_range(0, 8))
            0, 1:    sym = pfx_pkg::CHAR_PLUS;
            2, 3:    sym = pfx_pkg::CHAR_MINUS;
            4, 5:    sym = pfx_pkg::CHAR_MUL;
            6, 7:    sym = pfx_pkg::CHAR_DIV;
            default:
            begin
                do
                    sym = pfx_pkg::SYM_W'($urandom_range(0, 255));
                while ((sym >= pfx_pkg::CHAR_0 && sym <= pfx_pkg::CHAR_9) ||
                       sym == pfx_pkg::CHAR_PLUS || sym == pfx_pkg::CHAR_MINUS ||
                       sym == pfx_pkg::CHAR_MUL || sym == pfx_pkg::CHAR_DIV);
            end
        endcase
        return sym;
    endfunction

    // random valid postfix with the given number of operands
    task automatic build_well_formed(input int unsigned operands);
        int unsigned depth;
        int unsigned left;
        depth = 0;
        left  = operands;
        while (left > 0 || depth > 1)
        begin
            if (depth < 2 || (left > 0 && $urandom_range(0, 1) == 1))
            begin
                expr_chars.push_back(pick_digit());
                depth++;
                left--;
            end
            else
            begin
                expr_chars.push_back(pick_operator());
                depth--;
            end
        end
    endtask

    // long operand chains push values past 32 bits
    task automatic build_growth_chain();
        int unsigned links;
        links = $urandom_range(8, 16);
        expr_chars.push_back(pfx_pkg::CHAR_0 + pfx_pkg::SYM_W'($urandom_range(2, 9)));
        repeat (links)
        begin
            expr_chars.push_back(pfx_pkg::CHAR_0 + pfx_pkg::SYM_W'($urandom_range(1, 9)));
            case ($urandom_range(0, 5))
                0:       expr_chars.push_back(pfx_pkg::CHAR_MINUS);
                1:       expr_chars.push_back(pfx_pkg::CHAR_PLUS);
                2:       expr_chars.push_back(pfx_pkg::CHAR_DIV);
                default: expr_chars.push_back(pfx_pkg::CHAR_MUL);
            endcase
        end
    endtask

    // 2 * 8^10 wraps to the most negative value, then divided by 0 - 1
    task automatic build_most_negative_quotient();
        expr_chars.push_back(pfx_pkg::CHAR_0 + 8'd8);
        repeat (9)
        begin
            expr_chars.push_back(pfx_pkg::CHAR_0 + 8'd8);
            expr_chars.push_back(pfx_pkg::CHAR_MUL);
        end
        expr_chars.push_back(pfx_pkg::CHAR_0 + 8'd2);
        expr_chars.push_back(pfx_pkg::CHAR_MUL);
        expr_chars.push_back(pfx_pkg::CHAR_0);
        expr_chars.push_back(pfx_pkg::CHAR_0 + 8'd1);
        expr_chars.push_back(pfx_pkg::CHAR_MINUS);
        expr_chars.push_back(pfx_pkg::CHAR_DIV);
    endtask

    // fill the stack and push a few more, then fold some of it back
    task automatic build_overflow();
        repeat (pfx_pkg::STACK_DEPTH + $urandom_range(1, 4))
            expr_chars.push_back(pick_digit());
        repeat ($urandom_range(1, 6))
            expr_chars.push_back(pick_operator());
    endtask

    // ------------------------------------------------------------------------
    // input side: one transaction per call, bursts with random gaps
    // ------------------------------------------------------------------------
    task automatic send_symbol(input logic [pfx_pkg::SYM_W-1:0] sym, input logic last,
                               input logic checked, input result_t typed);
        result_t predicted;
        bit      gives_result;
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        gives_result = evaluate_symbol(sym, last, predicted);
        if (gives_result)
            awaited_results.push_back(checked ? typed : predicted);
        items_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 20);
        end
    endtask

    // the last symbol of the queue carries the end marker
    task automatic send_expression();
        int unsigned n;
        n = expr_chars.size();
        for (int unsigned i = 0; i < n; i++)
            send_symbol(expr_chars[i], i == n - 1, 1'b0, '0);
        expr_chars.delete();
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table rows, typed results where obvious, model elsewhere
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_symbol(DIRECTED_ROWS[i].sym, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].checked,
                        {DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].status});

        // the two long special cases go first, then the random mix
        build_overflow();
        send_expression();
        build_most_negative_quotient();
        send_expression();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > 400)
                hold_wanted = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 65)
                build_well_formed($urandom_range(1, 10));
            else if (pick < 75)
                build_growth_chain();
            else if (pick < 85)
            begin
                // broken: drop a character or slip in a stray operator
                build_well_formed($urandom_range(1, 6));
                if ($urandom_range(0, 1) == 1 && expr_chars.size() > 1)
                    expr_chars.delete($urandom_range(0, expr_chars.size() - 1));
                else
                    expr_chars.insert($urandom_range(0, expr_chars.size()), pick_operator());
            end
            else if (pick < 97)
            begin
                // noise: any byte at all
                repeat ($urandom_range(1, 8))
                    expr_chars.push_back(pfx_pkg::SYM_W'($urandom_range(0, 255)));
            end
            else if (pick < 98)
                build_most_negative_quotient();
            else
                build_overflow();
            send_expression();
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: stall patterns of its own, plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned span;
        bit          hold_served;
        hold_served = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_wanted && !hold_served)
            begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // scoreboard: each result transaction against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t                       want;
        logic [pfx_pkg::DATA_W-1:0]    got_value;
        logic [pfx_pkg::STATUS_W-1:0]  got_status;
        logic [pfx_pkg::OUT_PAD_W-1:0] got_pad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_value  = m_tdata[pfx_pkg::DATA_W-1:0];
            got_status = m_tdata[pfx_pkg::DATA_W +: pfx_pkg::STATUS_W];
            got_pad    = m_tdata[pfx_pkg::OUT_TDATA_W-1 -: pfx_pkg::OUT_PAD_W];
            if (awaited_results.size() == 0)
                log_fault($sformatf("unexpected result value %h status %0d",
                                    got_value, got_status));
            else
            begin
                want = awaited_results.pop_front();
                if (got_value !== want.value)
                    log_fault($sformatf("value mismatch: expected %h, got %h",
                                        want.value, got_value));
                if (got_status !== want.status)
                    log_fault($sformatf("status mismatch: expected %0d, got %0d",
                                        want.status, got_status));
                if (got_pad !== '0)
                    log_fault($sformatf("pad bits not zero: got %h", got_pad));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a transaction on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
